>>> sv/vector_euclidean_length_macros.svh
// Assertion macros shared by the vector_euclidean_length RTL.
`ifndef VECTOR_EUCLIDEAN_LENGTH_MACROS_SVH
`define VECTOR_EUCLIDEAN_LENGTH_MACROS_SVH

`ifndef SYNTH
`define VEL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vel: same-cycle check failed");
`define VEL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vel: next-cycle check failed");
`else
`define VEL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define VEL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/vel_pkg.sv
// Shared widths, constants and types for the vector length pipeline.
package vel_pkg;

   localparam int CW      = 16;                // component width
   localparam int COUNT_W = 3;
   localparam int LANES   = 4;
   localparam int SQ_W    = 2 * CW;            // one square
   localparam int SUM_W   = 2 * CW + 2;        // sum of four squares, even width
   localparam int ROOT_W  = SUM_W / 2;         // CW + 1 bits
   localparam int REM_W   = ROOT_W + 2;

   localparam int REQ_TDATA_W = ((LANES * CW + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((ROOT_W + 7) / 8) * 8;

   // smallest counts at which the third and fourth lanes are in use
   localparam logic [COUNT_W-1:0] USE_Z_MIN = 3'd3;
   localparam logic [COUNT_W-1:0] USE_W_MIN = 3'd4;

   localparam logic [CW-1:0]    MAG_ONE = {{(CW-1){1'b0}}, 1'b1};
   localparam logic [SUM_W-1:0] SUM_MAX = {2'b01, {SQ_W{1'b0}}};

   typedef logic [SQ_W-1:0] sq_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [SUM_W-1:0]  rad;
   } sqrt_stage_type;

endpackage

>>> sv/vel_square_sum.sv
// Magnitude, square and sum stages: three registered steps with valid bits.
`include "vector_euclidean_length_macros.svh"

module vel_square_sum (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [vel_pkg::COUNT_W-1:0]      count,
   input  logic [vel_pkg::CW-1:0]           comp [vel_pkg::LANES],
   output logic                             sum_valid,
   input  logic                             sum_ready,
   output logic [vel_pkg::SUM_W-1:0]        sum
);

   logic [vel_pkg::CW-1:0]   mag_ff [vel_pkg::LANES];
   logic [vel_pkg::CW-1:0]   mag_in [vel_pkg::LANES];
   logic [vel_pkg::SQ_W-1:0] sq_ff  [vel_pkg::LANES];
   logic [vel_pkg::SUM_W-1:0] sum_ff;
   logic v0_ff, v1_ff, v2_ff;
   logic r0, r1, r2;
   logic [vel_pkg::LANES-1:0] lane_use;

   assign r2 = !v2_ff || sum_ready;
   assign r1 = !v1_ff || r2;
   assign r0 = !v0_ff || r1;
   assign in_ready = r0;

   // x and y always count; counts below two act as two, above four as four
   assign lane_use = {count >= vel_pkg::USE_W_MIN, count >= vel_pkg::USE_Z_MIN, 2'b11};

   always_comb begin
      for (int i = 0; i < vel_pkg::LANES; i++) begin
         if (!lane_use[i]) begin
            mag_in[i] = '0;
         end else if (comp[i][vel_pkg::CW-1]) begin
            mag_in[i] = ~comp[i] + vel_pkg::MAG_ONE;
         end else begin
            mag_in[i] = comp[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (r0) v0_ff <= in_valid;
         if (r1) v1_ff <= v0_ff;
         if (r2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r0) begin
         mag_ff <= mag_in;
      end
      if (r1) begin
         for (int i = 0; i < vel_pkg::LANES; i++) begin
            sq_ff[i] <= vel_pkg::sq_type'(mag_ff[i]) * vel_pkg::sq_type'(mag_ff[i]);
         end
      end
      if (r2) begin
         sum_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]}
                 + {2'b00, sq_ff[2]} + {2'b00, sq_ff[3]};
      end
   end

   assign sum_valid = v2_ff;
   assign sum       = sum_ff;

   `VEL_ASSERT_IMPL(a_sum_bound, clock, reset, v2_ff, sum_ff <= vel_pkg::SUM_MAX)
   `VEL_ASSERT_NEXT(a_sum_held, clock, reset, v2_ff && !sum_ready, v2_ff)

endmodule

>>> sv/vel_isqrt.sv
// Pipelined integer square root, one root bit resolved per register stage.
`include "vector_euclidean_length_macros.svh"

module vel_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [vel_pkg::SUM_W-1:0]     rad,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [vel_pkg::ROOT_W-1:0]    root
);

   localparam int N = vel_pkg::ROOT_W;

   vel_pkg::sqrt_stage_type stage_ff [N];
   vel_pkg::sqrt_stage_type stage_in [N];
   logic [N-1:0] vld_ff;
   logic [N-1:0] rdy;

   for (genvar k = 0; k < N; k++) begin : g_stage
      vel_pkg::sqrt_stage_type prev;
      logic                    prev_vld;
      logic                    next_rdy;
      logic [vel_pkg::REM_W-1:0] cur;
      logic [vel_pkg::REM_W-1:0] trial;

      if (k == 0) begin : g_first
         assign prev     = '{rem: '0, root: '0, rad: rad};
         assign prev_vld = in_valid;
      end else begin : g_next
         assign prev     = stage_ff[k-1];
         assign prev_vld = vld_ff[k-1];
      end

      if (k == N - 1) begin : g_last
         assign next_rdy = out_ready;
      end else begin : g_mid
         assign next_rdy = rdy[k+1];
      end

      assign rdy[k] = !vld_ff[k] || next_rdy;

      // bring down the next two radicand bits and try root*4+1
      assign cur   = {prev.rem[vel_pkg::REM_W-3:0], prev.rad[vel_pkg::SUM_W-1 -: 2]};
      assign trial = {prev.root, 2'b01};

      always_comb begin
         stage_in[k].rad = {prev.rad[vel_pkg::SUM_W-3:0], 2'b00};
         if (cur >= trial) begin
            stage_in[k].rem  = cur - trial;
            stage_in[k].root = {prev.root[N-2:0], 1'b1};
         end else begin
            stage_in[k].rem  = cur;
            stage_in[k].root = {prev.root[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[N-1];
   assign root      = stage_ff[N-1].root;

   `VEL_ASSERT_IMPL(a_rem_bound, clock, reset, vld_ff[N-1],
      stage_ff[N-1].rem <= {1'b0, stage_ff[N-1].root, 1'b0})
   `VEL_ASSERT_NEXT(a_out_held, clock, reset, vld_ff[N-1] && !out_ready, vld_ff[N-1])
   `VEL_ASSERT_NEXT(a_mid_held, clock, reset, vld_ff[0] && !rdy[1], vld_ff[0])

endmodule

>>> sv/vector_euclidean_length.sv
// Path: from the accepting edge of a req beat to rsp_tvalid a vector passes the magnitude,
// square and sum registers, then 17 square-root stages, one root bit per stage.
// Throughput: one vector per cycle unless rsp stalls; every stage has its own valid bit
// and a stalled rsp side fills the pipeline bubble by bubble before req_tready drops.
// Reset (synchronous, active high) clears the valid bits only; no state is kept
// between beats, so the block is ready in the first cycle after reset.
module vector_euclidean_length (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // comp_x, comp_y, comp_z, comp_w from bit 0 up, 16 bits each
   input  logic [vel_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // component_count
   input  logic [vel_pkg::COUNT_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // length in bits 16:0, zero above
   output logic [vel_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   logic [vel_pkg::CW-1:0]     comp [vel_pkg::LANES];
   logic                       sum_valid;
   logic                       sum_ready;
   logic [vel_pkg::SUM_W-1:0]  sum;
   logic [vel_pkg::ROOT_W-1:0] length;

   always_comb begin
      for (int i = 0; i < vel_pkg::LANES; i++) begin
         comp[i] = req_tdata[i*vel_pkg::CW +: vel_pkg::CW];
      end
   end

   vel_square_sum u_square_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .count     (req_tuser),
      .comp      (comp),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .sum       (sum)
   );

   vel_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .rad       (sum),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .root      (length)
   );

   assign rsp_tdata = {{(vel_pkg::RSP_TDATA_W - vel_pkg::ROOT_W){1'b0}}, length};

endmodule

>>> sim/vector_euclidean_length_test.sv
`timescale 1ns / 1ps
// Self-checking bench for vector_euclidean_length: random vectors, random stalls, length checks.

class length_scoreboard;
   logic [vel_pkg::ROOT_W-1:0] expected_lengths[$];
   int unsigned                errors;

   function new();
      errors = 0;
   endfunction

   // floor of the root of the sum of squares over the lanes in use
   static function logic [vel_pkg::ROOT_W-1:0] euclid_length(
      input logic [vel_pkg::COUNT_W-1:0]     count,
      input logic [vel_pkg::REQ_TDATA_W-1:0] lanes
   );
      logic [vel_pkg::COUNT_W-1:0] used;
      logic [vel_pkg::CW-1:0]      comp;
      logic [vel_pkg::CW:0]        mag;
      logic [35:0]                 sum_sq;
      logic [35:0]                 trial_sq;
      logic [vel_pkg::ROOT_W-1:0]  root;
      logic [vel_pkg::ROOT_W-1:0]  trial;
      used = (count < 2) ? 3'd2 : (count > vel_pkg::LANES) ? 3'(vel_pkg::LANES) : count;
      sum_sq = '0;
      for (int i = 0; i < vel_pkg::LANES; i++) begin
         if (i < used) begin
            comp = lanes[i*vel_pkg::CW +: vel_pkg::CW];
            mag = comp[vel_pkg::CW-1] ?
                  (vel_pkg::CW+1)'((1 << vel_pkg::CW) - {1'b0, comp}) : {1'b0, comp};
            sum_sq += 36'(mag) * 36'(mag);
         end
      end
      root = '0;
      for (int b = vel_pkg::ROOT_W - 1; b >= 0; b--) begin
         trial = root | (vel_pkg::ROOT_W'(1) << b);
         trial_sq = 36'(trial) * 36'(trial);
         if (trial_sq <= sum_sq)
            root = trial;
      end
      return root;
   endfunction

   function void note_vector(input logic [vel_pkg::COUNT_W-1:0] count,
                             input logic [vel_pkg::REQ_TDATA_W-1:0] lanes);
      expected_lengths.push_back(euclid_length(count, lanes));
   endfunction

   function void check_length(input logic [vel_pkg::RSP_TDATA_W-1:0] word);
      logic [vel_pkg::ROOT_W-1:0] want;
      if (expected_lengths.size() == 0) begin
         $display("%0t: length beat with nothing expected, actual 0x%0h", $time, word);
         errors++;
      end else begin
         want = expected_lengths.pop_front();
         if (word !== vel_pkg::RSP_TDATA_W'(want)) begin
            $display("%0t: length mismatch, expected %0d, actual %0d (word 0x%0h)",
                     $time, want, word[vel_pkg::ROOT_W-1:0], word);
            errors++;
         end
      end
   endfunction

   function int pending();
      return expected_lengths.size();
   endfunction
endclass

module vector_euclidean_length_test;

   localparam int                     CYCLE_LIMIT  = 300000;
   localparam int                     RANDOM_ITEMS = 950;
   localparam logic [vel_pkg::CW-1:0] MOST_NEG     = 16'h8000;
   localparam logic [vel_pkg::CW-1:0] MOST_POS     = 16'h7fff;
   localparam logic [vel_pkg::CW-1:0] MINUS_ONE    = 16'hffff;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [vel_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [vel_pkg::COUNT_W-1:0]     req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [vel_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   length_scoreboard sb = new();
   bit               steady = 1'b0;   // no idling on either side while set
   int unsigned      cycle_count = 0;

   vector_euclidean_length dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // result side: check each accepted beat, then pick next cycle's tready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_length(rsp_tdata);
      rsp_tready <= steady || ($urandom_range(99) >= 20);
   end

   task automatic send_vector(input logic [vel_pkg::COUNT_W-1:0] count,
                              input logic [vel_pkg::CW-1:0] x, input logic [vel_pkg::CW-1:0] y,
                              input logic [vel_pkg::CW-1:0] z, input logic [vel_pkg::CW-1:0] w);
      while (!steady && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= count;
      req_tdata  <= {w, z, y, x};
      do @(posedge clock); while (!req_tready);
      sb.note_vector(count, {w, z, y, x});
   endtask

   task automatic drain_lengths();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic logic [vel_pkg::CW-1:0] pick_component();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 7)
         return vel_pkg::CW'($urandom());
      if (sel < 9) begin
         case ($urandom_range(4))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return MINUS_ONE;
            3: return '0;
            default: return 16'h0001;
         endcase
      end
      return vel_pkg::CW'($urandom_range(15)) - vel_pkg::CW'(8);
   endfunction

   initial begin
      logic [vel_pkg::COUNT_W-1:0] count;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // largest lengths, including clamped counts
      for (int c = 0; c < 8; c++)
         send_vector(3'(c), MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
      send_vector(3'd4, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
      send_vector(3'd4, MOST_POS, MOST_NEG, MOST_POS, MOST_NEG);
      send_vector(3'd2, '0, '0, '0, '0);
      // unused lanes hold garbage and must not matter
      send_vector(3'd2, 16'd3, 16'd4, MOST_NEG, MOST_NEG);
      send_vector(3'd3, 16'd2, MINUS_ONE, 16'hfffe, MOST_NEG);
      send_vector(3'd0, MINUS_ONE, 16'd1, MOST_POS, MOST_POS);
      send_vector(3'd1, '0, MOST_NEG, MINUS_ONE, MINUS_ONE);
      send_vector(3'd7, 16'd1, 16'd1, 16'd1, 16'd1);
      send_vector(3'd5, '0, '0, '0, MOST_NEG);
      send_vector(3'd6, 16'h5555, 16'haaaa, 16'h00ff, 16'hff00);
      send_vector(3'd3, 16'd1, '0, '0, MOST_POS);
      send_vector(3'd2, MOST_POS, MINUS_ONE, '0, '0);
      drain_lengths();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 250 || n == 700)
            drain_lengths();
         steady = (n >= 400 && n < 600);
         if ($urandom_range(9) < 7)
            count = 3'($urandom_range(4, 2));
         else
            count = 3'($urandom_range(7));
         send_vector(count, pick_component(), pick_component(),
                     pick_component(), pick_component());
      end
      steady = 1'b0;

      drain_lengths();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d lengths outstanding", cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
